// ===== design/fked_pkg.sv =====
// ----------------------------------------------------------------------------
// fked_pkg
// Shared types and constants for the function-key escape decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fked_pkg;

    // Character codes
    localparam logic [7:0] ESC_CODE     = 8'd27;
    localparam logic [7:0] OPEN_BRACKET = 8'h5B;
    localparam logic [7:0] LETTER_FIRST = 8'h41;
    localparam logic [7:0] LETTER_LAST  = 8'h45;
    localparam logic [7:0] FKEY_BASE    = 8'h81;

    // Item command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration
    localparam int          GAP_W         = 16;
    localparam logic [15:0] GAP_TICKS_RST = 16'd10;
    localparam int          CFG_ADDR_W    = 2;
    localparam logic [1:0]  REG_GAP_TICKS = 2'd0;

    // Job queue between front and back
    localparam int JOB_FIFO_DEPTH = 4;

    // Held bracket count after ESC, 0..2
    localparam int DEPTH_W = 2;

    // One job: ESC first if set, then the held brackets, then the tail byte
    typedef struct packed {
        logic               esc;
        logic [DEPTH_W-1:0] brackets;
        logic               tail_valid;
        logic [7:0]         tail_code;
        logic               tail_fk;
    } t_job;

endpackage

// ===== design/fked_front.sv =====
// ----------------------------------------------------------------------------
// fked_front
// Accepts keyboard bytes and ticks, tracks the escape-sequence state and
// turns each item that gives results into one job.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fked_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_cmd,
    input  logic [7:0]                 i_data_byte,
    input  logic [fked_pkg::GAP_W-1:0] i_gap_ticks,
    output logic                       o_push,
    output fked_pkg::t_job             o_job
);
    import fked_pkg::*;

    logic               r_in_seq, n_in_seq;
    logic [DEPTH_W-1:0] r_depth,  n_depth;
    logic [GAP_W-1:0]   r_gap,    n_gap;
    logic [GAP_W:0]     gap_inc;
    logic               is_letter;

    assign gap_inc   = {1'b0, r_gap} + {{GAP_W{1'b0}}, 1'b1};
    assign is_letter = (i_data_byte >= LETTER_FIRST) && (i_data_byte <= LETTER_LAST);

    // Classify the item and build its job
    always_comb begin
        n_in_seq = r_in_seq;
        n_depth  = r_depth;
        n_gap    = r_gap;
        o_push   = 1'b0;
        o_job    = '0;
        if (i_accept) begin
            if (i_cmd == CMD_TICK) begin
                if (r_in_seq) begin
                    if (gap_inc >= {1'b0, i_gap_ticks}) begin
                        // gap expired: flush ESC and held brackets
                        o_push         = 1'b1;
                        o_job.esc      = 1'b1;
                        o_job.brackets = r_depth;
                        n_in_seq       = 1'b0;
                        n_depth        = '0;
                        n_gap          = '0;
                    end else begin
                        n_gap = gap_inc[GAP_W-1:0];
                    end
                end
            end else if (!r_in_seq) begin
                if (i_data_byte == ESC_CODE) begin
                    n_in_seq = 1'b1;
                    n_depth  = '0;
                    n_gap    = '0;
                end else begin
                    o_push           = 1'b1;
                    o_job.tail_valid = 1'b1;
                    o_job.tail_code  = i_data_byte;
                end
            end else if (r_depth < DEPTH_W'(2) && i_data_byte == OPEN_BRACKET) begin
                n_depth = r_depth + DEPTH_W'(1);
                n_gap   = '0;
            end else if (r_depth == DEPTH_W'(2) && is_letter) begin
                // complete sequence: emit the function key
                o_push           = 1'b1;
                o_job.tail_valid = 1'b1;
                o_job.tail_code  = FKEY_BASE + (i_data_byte - LETTER_FIRST);
                o_job.tail_fk    = 1'b1;
                n_in_seq         = 1'b0;
                n_depth          = '0;
                n_gap            = '0;
            end else begin
                // mismatch: replay ESC, brackets and the byte itself
                o_push           = 1'b1;
                o_job.esc        = 1'b1;
                o_job.brackets   = r_depth;
                o_job.tail_valid = 1'b1;
                o_job.tail_code  = i_data_byte;
                n_in_seq         = 1'b0;
                n_depth          = '0;
                n_gap            = '0;
            end
        end
    end

    // Hold sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_seq <= 1'b0;
            r_depth  <= '0;
            r_gap    <= '0;
        end else begin
            r_in_seq <= n_in_seq;
            r_depth  <= n_depth;
            r_gap    <= n_gap;
        end
    end

endmodule

// ===== design/fked_fifo.sv =====
// ----------------------------------------------------------------------------
// fked_fifo
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fked_fifo #(
    parameter int DEPTH = fked_pkg::JOB_FIFO_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fked_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output fked_pkg::t_job o_head
);
    import fked_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers with wrap
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store job
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== design/fked_back.sv =====
// ----------------------------------------------------------------------------
// fked_back
// Expands each queued job into its results, one per cycle while the output
// is not stalled, into an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fked_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  fked_pkg::t_job i_head,
    output logic           o_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output logic [7:0]     o_key_code,
    output logic           o_is_function_key,
    output logic           o_last
);
    import fked_pkg::*;

    logic       r_busy, n_busy;
    t_job       r_cur,  n_cur;
    t_job       src, rest;
    logic       src_valid, slot_free, emit, more;
    logic       r_ovalid, n_ovalid;
    logic [7:0] r_code, e_code;
    logic       r_fk, e_fk;
    logic       r_last;

    // Work on the partly sent job first, else on the queue head
    assign src       = r_busy ? r_cur : i_head;
    assign src_valid = r_busy || !i_empty;
    assign slot_free = !r_ovalid || !i_stall;
    assign emit      = src_valid && slot_free;

    // Pick the next result and what remains of the job
    always_comb begin
        rest   = src;
        e_fk   = 1'b0;
        if (src.esc) begin
            e_code   = ESC_CODE;
            rest.esc = 1'b0;
        end else if (src.brackets != '0) begin
            e_code        = OPEN_BRACKET;
            rest.brackets = src.brackets - DEPTH_W'(1);
        end else begin
            e_code          = src.tail_code;
            e_fk            = src.tail_fk;
            rest.tail_valid = 1'b0;
        end
        more = rest.esc || (rest.brackets != '0) || rest.tail_valid;
    end

    assign o_pop = emit && !r_busy;

    always_comb begin
        n_busy   = r_busy;
        n_cur    = r_cur;
        n_ovalid = r_ovalid;
        if (emit) begin
            n_busy   = more;
            n_cur    = rest;
            n_ovalid = 1'b1;
        end else if (slot_free) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    // Load payload of the output register
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (emit) begin
            r_code <= e_code;
            r_fk   <= e_fk;
            r_last <= !more;
        end
    end

    assign o_valid           = r_ovalid;
    assign o_key_code        = r_code;
    assign o_is_function_key = r_fk;
    assign o_last            = r_last;

endmodule

// ===== design/function_key_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// function_key_escape_decoder
// Decodes ESC [ [ A..E into function-key codes 0x81..0x85 and passes or
// replays all other bytes.
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_stall  i_cmd, i_data_byte
//   result    out        o_valid / i_stall  o_key_code, o_is_function_key, o_last
//   config    in         APB psel/penable   paddr, pwdata, prdata (gap_ticks)
//
// The front takes one transaction per cycle while the job queue has room.
// The back sends one result per cycle while the output is not stalled; an
// item gives one to four results (ESC, up to two brackets, one byte).
// Held bytes and ticks that do not expire the gap give no job.
// Reset is synchronous; gap_ticks resets to 10. A stalled output holds
// its result while the front keeps filling the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module function_key_escape_decoder #(
    parameter int FIFO_DEPTH = fked_pkg::JOB_FIFO_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_cmd,
    input  logic [7:0]                      i_data_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_key_code,
    output logic                            o_is_function_key,
    output logic                            o_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fked_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import fked_pkg::*;

    logic [GAP_W-1:0] r_gap_ticks;
    logic             cfg_wr, accept;
    logic             push, pop, full, empty;
    t_job             job, head;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_GAP_TICKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_ticks <= GAP_TICKS_RST;
        end else if (cfg_wr) begin
            r_gap_ticks <= pwdata[GAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_GAP_TICKS) begin
            prdata = {{(32-GAP_W){1'b0}}, r_gap_ticks};
        end
    end

    // Input handshake
    assign o_stall = full;
    assign accept  = i_valid && !o_stall;

    fked_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (i_cmd),
        .i_data_byte (i_data_byte),
        .i_gap_ticks (r_gap_ticks),
        .o_push      (push),
        .o_job       (job)
    );

    fked_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    fked_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (empty),
        .i_head            (head),
        .o_pop             (pop),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_key_code        (o_key_code),
        .o_is_function_key (o_is_function_key),
        .o_last            (o_last)
    );

endmodule
